@@ hdl/pwb_pkg.sv @@
// Shared types and constants for the projective warp bilinear sampler.
package pwb_pkg;

  // Item operation codes
  localparam logic [1:0] OP_PIXEL  = 2'd0;
  localparam logic [1:0] OP_COEF   = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FILL_VALUE   = 2'd2;

  // Fixed field and datapath widths
  localparam int PIX_W  = 8;
  localparam int COEF_W = 32;
  localparam int DEST_W = 24;
  localparam int PROD_W = COEF_W + DEST_W;
  localparam int SUM_W  = 58;
  localparam int MAG_W  = 57;
  localparam int NUM_COEF = 9;

  // Control carried down the pipeline with every item
  typedef struct packed {
    logic [1:0]       op;
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
    logic [PIX_W-1:0] value;
  } pwb_ctl_t;

endpackage

@@ hdl/pwb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/pwb_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage, with range check.
module pwb_divider #(
  parameter int IB = 8,
  parameter int FB = 8
) (
  input  logic                    clk,
  input  logic [IB+FB:0]          ld,
  input  logic [pwb_pkg::MAG_W-1:0] n_in,
  input  logic [pwb_pkg::MAG_W-1:0] d_in,
  input  logic                    good_in,
  output logic [IB+FB-1:0]        q_out,
  output logic                    good_out
);
  import pwb_pkg::*;

  localparam int QB = IB + FB;
  localparam int DW = MAG_W + QB;

  logic [DW-1:0]    r  [QB];
  logic [MAG_W-1:0] dd [QB+1];
  logic [QB-1:0]    q  [QB+1];
  logic             g  [QB+1];

  // Set up the remainder and drop quotients whose integer part is too wide
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      r[0]  <= DW'(n_in) << FB;
      dd[0] <= d_in;
      q[0]  <= '0;
      g[0]  <= good_in && (DW'(n_in) < (DW'(d_in) << IB));
    end
  end

  // One compare and subtract per stage, most significant bit first
  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int K = QB - 1 - j;
    logic [DW-1:0] sub;
    logic          ge;
    assign sub = DW'(dd[j]) << K;
    assign ge  = (r[j] >= sub);
    always_ff @(posedge clk) begin
      if (ld[j+1]) begin
        dd[j+1] <= dd[j];
        g[j+1]  <= g[j];
        q[j+1]  <= {q[j][QB-2:0], ge};
      end
    end
    if (j < QB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (ld[j+1]) begin
          r[j+1] <= ge ? (r[j] - sub) : r[j];
        end
      end
    end
  end

  assign q_out    = q[QB];
  assign good_out = g[QB];

endmodule

@@ hdl/projective_warp_bilinear_sampler_top.sv @@
// Top level of the projective warp sampler with bilinear blend.
//
//  channel  | direction | handshake               | payload
//  item     | in        | item_valid / item_stall | op, pixel_*, coef_*, dest_x, dest_y
//  result   | out       | result_valid / result_stall | sample_value, inside_res
//  config   | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One item is accepted per cycle while item_stall is low; IB is the index width
// of the larger image dimension (8 at defaults), and the divider ahead of the
// four-bank pixel memory resolves one quotient bit per stage.
// Reset is synchronous; it clears pipeline valids and returns the configuration
// registers to their defaults; stores are not cleared.
// A stalled result holds the last stage and the full stages behind it; items fill empty stages.
module projective_warp_bilinear_sampler_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [1:0]                        op,
  input  logic [pwb_pkg::PIX_W-1:0]         pixel_col,
  input  logic [pwb_pkg::PIX_W-1:0]         pixel_row,
  input  logic [pwb_pkg::PIX_W-1:0]         pixel_value,
  input  logic [3:0]                        coef_index,
  input  logic signed [pwb_pkg::COEF_W-1:0] coef_value,
  input  logic signed [pwb_pkg::DEST_W-1:0] dest_x,
  input  logic signed [pwb_pkg::DEST_W-1:0] dest_y,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [pwb_pkg::PIX_W-1:0]         sample_value,
  output logic                              inside_res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [8:0]                        cfg_data
);
  import pwb_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int IB  = (CW > RW) ? CW : RW;
  localparam int QB  = IB + FRAC_BITS;
  localparam int CHW = (CW > 1) ? CW - 1 : 1;
  localparam int RHW = (RW > 1) ? RW - 1 : 1;
  localparam int AW  = CHW + RHW;
  localparam int R   = 5 + QB;
  localparam int NS  = R + 3;
  localparam int TW  = PIX_W + FRAC_BITS + 1;
  localparam int FW  = FRAC_BITS + 1;

  // Pipeline control
  logic [NS-1:0] v;
  logic [NS-1:0] ld;
  pwb_ctl_t      ctl [R];

  // Configuration registers
  logic [8:0]       image_width;
  logic [8:0]       image_height;
  logic [PIX_W-1:0] fill_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 9'd256;
      image_height <= 9'd256;
      fill_value   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_FILL_VALUE:   fill_value   <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage load enables: a stage takes a new item when empty or when it moves on
  always_comb begin
    ld[NS-1] = !v[NS-1] || !result_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign item_stall = !ld[0];

  // Advance valids; all but sample items leave at the memory stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (ld[k]) begin
          if (k == 0) begin
            v[k] <= item_valid;
          end else if (k == R) begin
            v[k] <= v[k-1] && (ctl[R-1].op == OP_SAMPLE);
          end else begin
            v[k] <= v[k-1];
          end
        end
      end
    end
  end

  // Control travels with each item up to the memory stage
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      ctl[0] <= '{op: op, col: pixel_col, row: pixel_row, value: pixel_value};
    end
    for (int k = 1; k < R; k++) begin
      if (ld[k]) begin
        ctl[k] <= ctl[k-1];
      end
    end
  end

  // Stage 0: input registers
  logic [3:0]               s0_cidx;
  logic signed [COEF_W-1:0] s0_cval;
  logic signed [DEST_W-1:0] s0_dx;
  logic signed [DEST_W-1:0] s0_dy;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s0_cidx <= coef_index;
      s0_cval <= coef_value;
      s0_dx   <= dest_x;
      s0_dy   <= dest_y;
    end
  end

  // Coefficient store, written in item order as the item leaves stage 0
  logic signed [COEF_W-1:0] coef [NUM_COEF];

  always_ff @(posedge clk) begin
    if (v[0] && ld[1] && ctl[0].op == OP_COEF && s0_cidx < 4'(NUM_COEF)) begin
      coef[s0_cidx] <= s0_cval;
    end
  end

  // Stage 1: products
  logic signed [PROD_W-1:0] prod [6];
  logic signed [COEF_W-1:0] cc   [3];

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      prod[0] <= coef[0] * s0_dx;
      prod[1] <= coef[1] * s0_dy;
      prod[2] <= coef[3] * s0_dx;
      prod[3] <= coef[4] * s0_dy;
      prod[4] <= coef[6] * s0_dx;
      prod[5] <= coef[7] * s0_dy;
      cc[0]   <= coef[2];
      cc[1]   <= coef[5];
      cc[2]   <= coef[8];
    end
  end

  // Stage 2: homogeneous sums
  logic signed [SUM_W-1:0] sx, sy, sz;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      sx <= SUM_W'(prod[0]) + SUM_W'(prod[1]) + (SUM_W'(cc[0]) <<< 8);
      sy <= SUM_W'(prod[2]) + SUM_W'(prod[3]) + (SUM_W'(cc[1]) <<< 8);
      sz <= SUM_W'(prod[4]) + SUM_W'(prod[5]) + (SUM_W'(cc[2]) <<< 8);
    end
  end

  // Stage 3: magnitudes, zero divisor and negative quotient checks
  logic [MAG_W-1:0] nx, ny, nd;
  logic             s3_good;
  logic             sx_neg, sy_neg;

  assign sx_neg = (sx != '0) && (sx[SUM_W-1] != sz[SUM_W-1]);
  assign sy_neg = (sy != '0) && (sy[SUM_W-1] != sz[SUM_W-1]);

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      nx      <= sx[SUM_W-1] ? MAG_W'(-sx) : MAG_W'(sx);
      ny      <= sy[SUM_W-1] ? MAG_W'(-sy) : MAG_W'(sy);
      nd      <= sz[SUM_W-1] ? MAG_W'(-sz) : MAG_W'(sz);
      s3_good <= (sz != '0) && !sx_neg && !sy_neg;
    end
  end

  // Stages 4 to 4+QB: quotient of each coordinate
  logic [QB-1:0] qx, qy;
  logic          gx, gy;

  pwb_divider #(.IB(IB), .FB(FRAC_BITS)) u_div_x (
    .clk(clk), .ld(ld[4+QB:4]), .n_in(nx), .d_in(nd), .good_in(s3_good),
    .q_out(qx), .good_out(gx)
  );

  pwb_divider #(.IB(IB), .FB(FRAC_BITS)) u_div_y (
    .clk(clk), .ld(ld[4+QB:4]), .n_in(ny), .d_in(nd), .good_in(s3_good),
    .q_out(qy), .good_out(gy)
  );

  // Neighbour range check and bank addressing
  logic [IB-1:0]        ix, iy;
  logic [FRAC_BITS-1:0] fx, fy;
  logic [12:0]          w_eff, h_eff;
  logic                 in_range;
  logic [CHW-1:0]       ch_even, ch_odd;
  logic [RHW-1:0]       rh_even, rh_odd;
  logic [AW-1:0]        raddr [4];

  assign ix = qx[QB-1:FRAC_BITS];
  assign iy = qy[QB-1:FRAC_BITS];
  assign fx = qx[FRAC_BITS-1:0];
  assign fy = qy[FRAC_BITS-1:0];

  assign w_eff = (13'(image_width) < 13'(MAX_WIDTH)) ? 13'(image_width) : 13'(MAX_WIDTH);
  assign h_eff = (13'(image_height) < 13'(MAX_HEIGHT)) ? 13'(image_height) : 13'(MAX_HEIGHT);
  assign in_range = gx && gy && ((14'(ix) + 14'd1) < 14'(w_eff))
                             && ((14'(iy) + 14'd1) < 14'(h_eff));

  assign ch_odd  = CHW'(ix >> 1);
  assign ch_even = ix[0] ? CHW'((ix >> 1) + IB'(1)) : CHW'(ix >> 1);
  assign rh_odd  = RHW'(iy >> 1);
  assign rh_even = iy[0] ? RHW'((iy >> 1) + IB'(1)) : RHW'(iy >> 1);

  // Bank order: row parity then column parity
  assign raddr[0] = {rh_even, ch_even};
  assign raddr[1] = {rh_even, ch_odd};
  assign raddr[2] = {rh_odd,  ch_even};
  assign raddr[3] = {rh_odd,  ch_odd};

  // Pixel write, done in item order at the memory stage
  logic [15:0]    wcol16, wrow16;
  logic [CW-1:0]  wcol;
  logic [RW-1:0]  wrow;
  logic           wr_ok;
  logic [AW-1:0]  waddr;
  logic [1:0]     wbank;

  assign wcol16 = {8'd0, ctl[R-1].col};
  assign wrow16 = {8'd0, ctl[R-1].row};
  assign wcol   = wcol16[CW-1:0];
  assign wrow   = wrow16[RW-1:0];
  assign wr_ok  = v[R-1] && ld[R] && (ctl[R-1].op == OP_PIXEL)
               && (wcol16 < 16'(MAX_WIDTH)) && (wrow16 < 16'(MAX_HEIGHT));
  assign waddr  = {RHW'(wrow >> 1), CHW'(wcol >> 1)};
  assign wbank  = {wrow[0], wcol[0]};

  logic [PIX_W-1:0] rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    pwb_ram #(.WIDTH(PIX_W), .DEPTH(2 ** AW)) u_bank (
      .clk(clk), .we(wr_ok && (wbank == 2'(b))), .waddr(waddr),
      .wdata(ctl[R-1].value), .re(ld[R]), .raddr(raddr[b]), .rdata(rd[b])
    );
  end

  // Stage R: fractions and parities beside the read data
  logic [FRAC_BITS-1:0] r_fx, r_fy;
  logic                 r_ix0, r_iy0, r_inside;

  always_ff @(posedge clk) begin
    if (ld[R]) begin
      r_fx     <= fx;
      r_fy     <= fy;
      r_ix0    <= ix[0];
      r_iy0    <= iy[0];
      r_inside <= in_range;
    end
  end

  // Stage R+1: horizontal blend
  logic [PIX_W-1:0]     p00, p01, p10, p11;
  logic [FW-1:0]        omfx;
  logic [TW-1:0]        t0, t1;
  logic [FRAC_BITS-1:0] h_fy;
  logic                 h_inside;

  assign p00  = rd[{r_iy0,  r_ix0}];
  assign p01  = rd[{r_iy0, ~r_ix0}];
  assign p10  = rd[{~r_iy0,  r_ix0}];
  assign p11  = rd[{~r_iy0, ~r_ix0}];
  assign omfx = {1'b1, FRAC_BITS'(0)} - {1'b0, r_fx};

  always_ff @(posedge clk) begin
    if (ld[R+1]) begin
      t0       <= TW'(p00) * TW'(omfx) + TW'(p01) * TW'(r_fx);
      t1       <= TW'(p10) * TW'(omfx) + TW'(p11) * TW'(r_fx);
      h_fy     <= r_fy;
      h_inside <= r_inside;
    end
  end

  // Stage R+2: vertical blend, truncate, or fill
  localparam int AccW = TW + FW;
  logic [FW-1:0]   omfy;
  logic [AccW-1:0] acc;

  assign omfy = {1'b1, FRAC_BITS'(0)} - {1'b0, h_fy};
  assign acc  = AccW'(t0) * AccW'(omfy) + AccW'(t1) * AccW'(h_fy);

  always_ff @(posedge clk) begin
    if (ld[NS-1]) begin
      sample_value <= h_inside ? acc[2*FRAC_BITS +: PIX_W] : fill_value;
      inside_res   <= h_inside;
    end
  end

  assign result_valid = v[NS-1];

  // A sample that enters the memory stage is held there
  a_sample_reaches_read: assert property (@(posedge clk) disable iff (rst)
    (v[R-1] && ld[R] && ctl[R-1].op == OP_SAMPLE) |=> v[R])
    else $error("sample lost at memory stage");

  // Write items never reach the result side
  a_write_dropped: assert property (@(posedge clk) disable iff (rst)
    (v[R-1] && ld[R] && ctl[R-1].op != OP_SAMPLE) |=> !v[R])
    else $error("write item passed memory stage");

  // Stall only when the first stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> v[0])
    else $error("item stall with empty input stage");

  // A free result side never stalls the input
  a_stall_chain: assert property (@(posedge clk) disable iff (rst)
    !result_stall |-> !item_stall)
    else $error("input stalled while result side free");

endmodule

@@ sim/tb_projective_warp_bilinear_sampler_top.sv @@
// Self-checking testbench for the projective warp bilinear sampler top level.
`timescale 1ns / 100ps

module tb_projective_warp_bilinear_sampler_top;
  import pwb_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ONE_Q16 = 65536;
  localparam int LOAD_W = 32;
  localparam int LOAD_H = 16;

  typedef struct {
    logic [7:0] value;
    logic       in_img;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] op = OP_UNUSED;
  logic [7:0] pixel_col = '0;
  logic [7:0] pixel_row = '0;
  logic [7:0] pixel_value = '0;
  logic [3:0] coef_index = '0;
  logic signed [31:0] coef_value = '0;
  logic signed [23:0] dest_x = '0;
  logic signed [23:0] dest_y = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [7:0] sample_value;
  logic inside_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  // Shadow state of the block
  logic [7:0] pixel_mdl [0:65535];
  logic signed [31:0] warp_mdl [0:8];
  logic [8:0] width_mdl, height_mdl;
  logic [7:0] fill_mdl;
  sample_t samples_due [$];

  int errors = 0;
  int cycles = 0;
  bit idling = 1'b1;
  int stall_left = 0;

  projective_warp_bilinear_sampler_top dut (.*);

  always #6 clk = ~clk;

  // Floor of num*2^8/den for a non-negative quotient
  function automatic bit warp_divide(longint num, longint den,
                                     output longint ip, output longint fr);
    logic [127:0] n, d, r;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    ip = 0;
    fr = 0;
    if (n != 0 && ((num < 0) != (den < 0))) return 1'b0;
    ip = n / d;
    r = n % d;
    fr = (r << 8) / d;
    return 1'b1;
  endfunction

  function automatic sample_t warp_sample(logic signed [23:0] x, logic signed [23:0] y);
    sample_t s;
    longint sx, sy, sz, ix, iy, fx, fy, w, h, acc;
    longint p00, p01, p10, p11;
    int base;
    sx = longint'(warp_mdl[0]) * x + longint'(warp_mdl[1]) * y + longint'(warp_mdl[2]) * 256;
    sy = longint'(warp_mdl[3]) * x + longint'(warp_mdl[4]) * y + longint'(warp_mdl[5]) * 256;
    sz = longint'(warp_mdl[6]) * x + longint'(warp_mdl[7]) * y + longint'(warp_mdl[8]) * 256;
    s.value = fill_mdl;
    s.in_img = 1'b0;
    if (sz == 0) return s;
    if (!warp_divide(sx, sz, ix, fx)) return s;
    if (!warp_divide(sy, sz, iy, fy)) return s;
    w = (width_mdl < 256) ? width_mdl : 256;
    h = (height_mdl < 256) ? height_mdl : 256;
    if (ix + 1 >= w || iy + 1 >= h) return s;
    base = iy * 256 + ix;
    p00 = pixel_mdl[base];
    p01 = pixel_mdl[base + 1];
    p10 = pixel_mdl[base + 256];
    p11 = pixel_mdl[base + 257];
    acc = (p00 * (256 - fx) + p01 * fx) * (256 - fy) + (p10 * (256 - fx) + p11 * fx) * fy;
    s.value = acc[23:16];
    s.in_img = 1'b1;
    return s;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("error @%0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Track accepted items and config writes, check each accepted result
  always @(posedge clk) begin
    sample_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (samples_due.size() == 0) begin
          report_mismatch("unexpected result, value", sample_value, -1);
        end else begin
          want = samples_due.pop_front();
          if (sample_value !== want.value)
            report_mismatch("sample_value", sample_value, want.value);
          if (inside_res !== want.in_img)
            report_mismatch("inside_res", inside_res, want.in_img);
        end
      end
      if (item_valid && !item_stall) begin
        case (op)
          OP_PIXEL: pixel_mdl[{pixel_row, pixel_col}] = pixel_value;
          OP_COEF: if (coef_index < NUM_COEF) warp_mdl[coef_index] = coef_value;
          OP_SAMPLE: samples_due.push_back(warp_sample(dest_x, dest_y));
          default: ;
        endcase
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: width_mdl = cfg_data;
          REG_IMAGE_HEIGHT: height_mdl = cfg_data;
          REG_FILL_VALUE: fill_mdl = cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // Stall the result side in random bursts while idling is set
  always @(posedge clk) begin
    if (!idling) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(7) == 0) begin
      result_stall <= 1'b1;
      stall_left <= $urandom_range(5);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("projective_warp_bilinear_sampler_top: mismatch");
      $finish;
    end
  end

  // Send one item, with an optional random gap ahead of it
  task automatic send_item(logic [1:0] o, logic [7:0] col, logic [7:0] row,
                           logic [7:0] val, logic [3:0] idx, logic [31:0] cv,
                           logic [23:0] x, logic [23:0] y);
    if (idling && $urandom_range(5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    item_valid <= 1'b1;
    op <= o;
    pixel_col <= col;
    pixel_row <= row;
    pixel_value <= val;
    coef_index <= idx;
    coef_value <= cv;
    dest_x <= x;
    dest_y <= y;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic put_pixel(int col, int row, int val);
    send_item(OP_PIXEL, col, row, val, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic put_coef(int idx, int val);
    send_item(OP_COEF, $urandom, $urandom, $urandom, idx, val, $urandom, $urandom);
  endtask

  task automatic put_sample(int x, int y);
    send_item(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom, x, y);
  endtask

  // Wait for the block to drain, then write one register
  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    item_valid <= 1'b0;
    @(posedge clk);
    while (samples_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_identity();
    for (int k = 0; k < NUM_COEF; k++)
      put_coef(k, (k == 0 || k == 4 || k == 8) ? ONE_Q16 : 0);
  endtask

  // Near-identity warp with random scale, shear, offset and slight perspective
  task automatic load_random_warp();
    put_coef(0, ONE_Q16 + $signed($urandom_range(16384)) - 8192);
    put_coef(1, $signed($urandom_range(8192)) - 4096);
    put_coef(2, $signed($urandom_range(ONE_Q16 * 16)) - ONE_Q16 * 8);
    put_coef(3, $signed($urandom_range(8192)) - 4096);
    put_coef(4, ONE_Q16 + $signed($urandom_range(16384)) - 8192);
    put_coef(5, $signed($urandom_range(ONE_Q16 * 16)) - ONE_Q16 * 8);
    put_coef(6, $signed($urandom_range(8)) - 4);
    put_coef(7, $signed($urandom_range(8)) - 4);
    put_coef(8, ONE_Q16 + $signed($urandom_range(2048)) - 1024);
  endtask

  // Load the image region, limit the valid area to it and load the identity warp
  task automatic test_load_image();
    for (int r = 0; r < LOAD_H; r++)
      for (int c = 0; c < LOAD_W; c++) put_pixel(c, r, $urandom);
    write_reg(REG_IMAGE_WIDTH, LOAD_W);
    write_reg(REG_IMAGE_HEIGHT, LOAD_H);
    load_identity();
  endtask

  task automatic test_directed();
    put_pixel(0, 0, 8'hff);
    put_pixel(255, 255, 8'h00);
    put_pixel(1, 0, 8'h00);
    put_sample(0, 0);
    put_sample(24'h80, 24'h80);
    put_sample(24'h1eff, 24'h0eff);
    put_sample(24'h1f00, 24'h0);
    put_sample(24'h0, 24'h0f00);
    put_sample(-1, 24'h100);
    put_sample(24'h100, -256);
    put_sample(24'h7fffff, 24'h7fffff);
    put_sample(24'h800000, 24'h800000);
    // write outside the coefficient range and the unused op: both ignored
    send_item(OP_COEF, 0, 0, 0, 4'hf, 32'h7fffffff, 0, 0);
    send_item(OP_UNUSED, 8'hff, 8'hff, 8'hff, 4'hf, 32'hffffffff, 24'hffffff, 24'hffffff);
    put_sample(24'h0934, 24'h0578);
    // zero divisor
    put_coef(8, 0);
    put_sample(0, 0);
    put_sample(24'h100, 24'h100);
    put_coef(8, 32'h80000000);
    put_sample(24'h100, 24'h100);
    put_coef(0, 32'h7fffffff);
    put_sample(24'h100, 24'h100);
    load_identity();
  endtask

  task automatic test_config_sweep();
    int widths [6] = '{1, 0, 2, 511, 3, 256};
    for (int i = 0; i < 6; i++) begin
      write_reg(REG_IMAGE_WIDTH, widths[i]);
      write_reg(REG_IMAGE_HEIGHT, widths[5 - i]);
      write_reg(REG_FILL_VALUE, (i % 2) ? 9'h1ff : 9'h000);
      put_sample(0, 0);
      put_sample(24'h180, 24'h180);
      put_sample(24'hfe80, 24'h140);
      put_sample(-24'h100, 0);
    end
    write_reg(REG_UNUSED, 9'h155);
    write_reg(REG_FILL_VALUE, 9'h0a5);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70)
      put_sample($urandom_range(LOAD_W * 256 + 1024) - 512,
                 $urandom_range(LOAD_H * 256 + 1024) - 512);
    else if (pick < 78)
      put_pixel($urandom, $urandom, $urandom);
    else if (pick < 81)
      load_random_warp();
    else if (pick < 84)
      put_coef($urandom_range(8), $urandom);
    else if (pick < 86)
      load_identity();
    else if (pick < 92)
      put_sample($urandom, $urandom);
    else if (pick < 95)
      send_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
    else
      send_item(OP_COEF, $urandom, $urandom, $urandom, $urandom_range(15, 9), $urandom,
                $urandom, $urandom);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(REG_IMAGE_WIDTH, $urandom_range(LOAD_W, LOAD_W - 8));
      write_reg(REG_IMAGE_HEIGHT, $urandom_range(LOAD_H, LOAD_H - 8));
      write_reg(REG_FILL_VALUE, $urandom);
      for (int i = 0; i < 220; i++) random_item();
    end
  endtask

  task automatic test_back_to_back();
    write_reg(REG_IMAGE_WIDTH, LOAD_W);
    write_reg(REG_IMAGE_HEIGHT, LOAD_H);
    idling = 1'b0;
    for (int i = 0; i < 150; i++) random_item();
  endtask

  initial begin
    width_mdl = 256;
    height_mdl = 256;
    fill_mdl = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_image();
    test_directed();
    test_config_sweep();
    test_random();
    test_back_to_back();
    item_valid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("projective_warp_bilinear_sampler_top: match");
    else
      $display("projective_warp_bilinear_sampler_top: mismatch");
    $finish;
  end

endmodule
